FILE: rtl/psr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psr_pkg
// Shared constants and types of the protected save RAM.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int unsigned MEM_DEPTH_DEF = 32768;
    localparam int unsigned ADDR_W        = 15;
    localparam int unsigned DATA_W        = 8;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [ADDR_W-1:0] CMD_ADDR_A = 15'h5555;
    localparam logic [ADDR_W-1:0] CMD_ADDR_B = 15'h2AAA;

    localparam logic [DATA_W-1:0] CMD_UNLOCK_1 = 8'hAA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK_2 = 8'h55;
    localparam logic [DATA_W-1:0] CMD_PROT_ON  = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_ERASE    = 8'h80;
    localparam logic [DATA_W-1:0] CMD_PROT_OFF = 8'h20;
    localparam logic [DATA_W-1:0] ERASED_BYTE  = 8'hFF;

    typedef struct packed {
        logic swallow;
        logic prot_now;
        logic prot_next;
    } t_seq_stat;

endpackage
`default_nettype wire

FILE: rtl/psr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psr_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module psr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32768,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/psr_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psr_seq
// Command sequence matcher and write-protect flag.
// ----------------------------------------------------------------------------
module psr_seq
    import psr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    output t_seq_stat              o_stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_KEY1  = 3'd1;
    localparam logic [2:0] ST_KEY2  = 3'd2;
    localparam logic [2:0] ST_ERASE = 3'd3;
    localparam logic [2:0] ST_KEY4  = 3'd4;
    localparam logic [2:0] ST_KEY5  = 3'd5;

    logic [2:0] r_step, n_step;
    logic       r_prot, n_prot;
    logic       w_hit;
    logic       hit_a, hit_b;

    assign hit_a = (i_address == CMD_ADDR_A);
    assign hit_b = (i_address == CMD_ADDR_B);

    always_comb begin
        n_step = ST_IDLE;
        n_prot = r_prot;
        w_hit  = 1'b0;
        case (r_step)
            ST_IDLE, ST_ERASE: begin
                if (hit_a && i_write_data == CMD_UNLOCK_1) begin
                    w_hit  = 1'b1;
                    n_step = r_step + 3'd1;
                end
            end
            ST_KEY1, ST_KEY4: begin
                if (hit_b && i_write_data == CMD_UNLOCK_2) begin
                    w_hit  = 1'b1;
                    n_step = r_step + 3'd1;
                end
            end
            ST_KEY2: begin
                if (hit_a && i_write_data == CMD_PROT_ON) begin
                    w_hit  = 1'b1;
                    n_prot = 1'b1;
                end else if (hit_a && i_write_data == CMD_ERASE) begin
                    w_hit  = 1'b1;
                    n_step = ST_ERASE;
                end
            end
            ST_KEY5: begin
                if (hit_a && i_write_data == CMD_PROT_OFF) begin
                    w_hit  = 1'b1;
                    n_prot = 1'b0;
                end
            end
            default: begin
                w_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
            r_prot <= 1'b0;
        end else if (i_wr_en) begin
            r_step <= n_step;
            r_prot <= n_prot;
        end
    end

    assign o_stat.swallow   = w_hit;
    assign o_stat.prot_now  = r_prot;
    assign o_stat.prot_next = i_wr_en ? n_prot : r_prot;

endmodule
`default_nettype wire

FILE: rtl/protected_save_ram_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// protected_save_ram_unit
// Byte save memory with command-sequence write protection.
//
// Input channel (i_valid / o_stall) carries one access: kind, address and
// write data. Output channel (o_valid / i_stall) returns one item per access:
// the stored byte for a read (zero for a write) and the protect state after it.
// An accepted access enters the RAM read stage and then the output register,
// which drives o_valid. One access per cycle is sustained while i_stall is
// low, set by the single RAM port (one read or one write per cycle).
// Writes that are neither swallowed nor protected update the RAM in the cycle
// they are accepted, so a following read of the same byte sees the new value.
// After reset the block sweeps the RAM to 0xFF, one byte per cycle; o_stall
// stays high until the sweep is done. Protection is off and the matcher is
// at its first step after reset.
// When i_stall is held, one item waits in the output register and one more
// in the RAM read stage; further accesses are then stalled.
// ----------------------------------------------------------------------------
module protected_save_ram_unit
    import psr_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_kind,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [DATA_W-1:0] o_read_data,
    output logic                   o_protect_on
);

    localparam int unsigned AW = $clog2(MEM_DEPTH);

    logic              r_clr;
    logic [AW-1:0]     r_clr_cnt;
    logic              r_p_vld, r_p_wr, r_p_prot;
    logic              r_o_vld, r_o_prot;
    logic [DATA_W-1:0] r_o_data;

    logic              w_acc, w_acc_wr, w_move, w_p_free;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_addr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    t_seq_stat         w_stat;

    assign w_move   = r_p_vld && (!r_o_vld || !i_stall);
    assign w_p_free = !r_p_vld || w_move;
    assign o_stall  = r_clr || !w_p_free;
    assign w_acc    = i_valid && !o_stall;
    assign w_acc_wr = w_acc && (i_kind == KIND_WRITE);

    psr_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (w_acc_wr),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_stat       (w_stat)
    );

    assign ram_we    = r_clr || (w_acc_wr && !w_stat.swallow && !w_stat.prot_now);
    assign ram_re    = w_acc && (i_kind == KIND_READ);
    assign ram_addr  = r_clr ? r_clr_cnt : AW'(i_address);
    assign ram_wdata = r_clr ? ERASED_BYTE : i_write_data;

    psr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == AW'(MEM_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_p_free) begin
                r_p_vld <= w_acc;
            end
            if (w_move) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_p_wr   <= (i_kind == KIND_WRITE);
            r_p_prot <= w_stat.prot_next;
        end
        if (w_move) begin
            r_o_data <= r_p_wr ? '0 : ram_rdata;
            r_o_prot <= r_p_prot;
        end
    end

    assign o_valid      = r_o_vld;
    assign o_read_data  = r_o_data;
    assign o_protect_on = r_o_prot;

    // assertions
    a_no_acc_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> o_stall)
        else $error("access taken during RAM sweep");

    a_empty_after_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr) |-> (!r_p_vld && !r_o_vld))
        else $error("pipeline not empty at end of sweep");

    a_p_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_vld && r_o_vld && i_stall) |=> r_p_vld)
        else $error("read stage item lost under stall");

    a_prot_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc_wr |=> $stable(w_stat.prot_now))
        else $error("protect flag changed without a write");

    a_sweep_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_wr && w_stat.prot_now) |-> !ram_we)
        else $error("store written while protected");

endmodule
`default_nettype wire

FILE: tb/tb_protected_save_ram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_protected_save_ram_unit
// Checks the protected save RAM against a cycle-free model of the store, the
// protect flag and the command matcher. A directed opening covers the address
// extremes, the on and off sequences, reads inside a sequence and broken
// sequences. Random command runs, broken runs and plain accesses follow.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the block fills up and stalls.
// ----------------------------------------------------------------------------
module tb_protected_save_ram_unit;
    import psr_pkg::*;

    typedef struct {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_access;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              protect_on;
    } t_outcome;

    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 60;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              i_kind = KIND_READ;
    logic [ADDR_W-1:0] i_address = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [DATA_W-1:0] o_read_data;
    logic              o_protect_on;

    t_access  pending_accesses[$];
    t_outcome awaited_results[$];
    t_access  on_bus;

    logic [DATA_W-1:0] mem_model [MEM_DEPTH_DEF];
    logic              prot_model = 1'b0;
    logic [2:0]        step_model = 3'd0;

    int  total_items = 0;
    int  accepted = 0;
    int  received = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  failed = 1'b0;

    protected_save_ram_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_protect_on (o_protect_on)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #5ms;
        $display("tb_protected_save_ram_unit: FAIL");
        $finish;
    end

    // model of one access; the matcher swallows writes that hit the next step
    task automatic apply_access(input t_access a, output t_outcome r);
        bit swallowed;
        swallowed = 1'b0;
        r.read_data = '0;
        if (a.kind == KIND_READ) begin
            r.read_data = mem_model[a.addr];
        end else begin
            case (step_model)
                3'd0, 3'd3: begin
                    if (a.addr == CMD_ADDR_A && a.data == CMD_UNLOCK_1) begin
                        step_model = step_model + 3'd1;
                        swallowed = 1'b1;
                    end
                end
                3'd1, 3'd4: begin
                    if (a.addr == CMD_ADDR_B && a.data == CMD_UNLOCK_2) begin
                        step_model = step_model + 3'd1;
                        swallowed = 1'b1;
                    end
                end
                3'd2: begin
                    if (a.addr == CMD_ADDR_A && a.data == CMD_PROT_ON) begin
                        prot_model = 1'b1;
                        step_model = 3'd0;
                        swallowed = 1'b1;
                    end else if (a.addr == CMD_ADDR_A && a.data == CMD_ERASE) begin
                        step_model = 3'd3;
                        swallowed = 1'b1;
                    end
                end
                3'd5: begin
                    if (a.addr == CMD_ADDR_A && a.data == CMD_PROT_OFF) begin
                        prot_model = 1'b0;
                        step_model = 3'd0;
                        swallowed = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!swallowed) begin
                step_model = 3'd0;
                if (!prot_model) mem_model[a.addr] = a.data;
            end
        end
        r.protect_on = prot_model;
    endtask

    task automatic push_read(input logic [ADDR_W-1:0] addr);
        t_access a;
        a.kind = KIND_READ;
        a.addr = addr;
        a.data = logic'($urandom_range(1)) ? 8'($urandom) : '0;
        pending_accesses.push_back(a);
    endtask

    task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        t_access a;
        a.kind = KIND_WRITE;
        a.addr = addr;
        a.data = data;
        pending_accesses.push_back(a);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) return logic'($urandom_range(1)) ? CMD_ADDR_A : CMD_ADDR_B;
        if (pick < 45) return ADDR_W'($urandom_range(15));
        if (pick < 60) return ADDR_W'(32767 - $urandom_range(15));
        return ADDR_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(9))
            0: return CMD_UNLOCK_1;
            1: return CMD_UNLOCK_2;
            2: return CMD_PROT_ON;
            3: return CMD_ERASE;
            4: return CMD_PROT_OFF;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // command write, now and then with a read slipped in ahead of it
    task automatic push_step(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        if ($urandom_range(99) < 15) push_read(pick_address());
        push_write(addr, data);
    endtask

    initial begin
        logic [ADDR_W-1:0] off_addr [6];
        logic [DATA_W-1:0] off_data [6];
        int pick;
        int cut;

        off_addr = '{CMD_ADDR_A, CMD_ADDR_B, CMD_ADDR_A, CMD_ADDR_A, CMD_ADDR_B, CMD_ADDR_A};
        off_data = '{CMD_UNLOCK_1, CMD_UNLOCK_2, CMD_ERASE,
                     CMD_UNLOCK_1, CMD_UNLOCK_2, CMD_PROT_OFF};
        for (int k = 0; k < MEM_DEPTH_DEF; k++) mem_model[k] = ERASED_BYTE;

        push_read(15'h0000);
        push_read(15'h7FFF);
        push_write(15'h0000, 8'h00);
        push_write(15'h7FFF, 8'h5A);
        push_read(15'h0000);
        push_read(15'h7FFF);
        push_write(CMD_ADDR_A, CMD_UNLOCK_1);
        push_read(15'h0000);
        push_write(CMD_ADDR_B, CMD_UNLOCK_2);
        push_write(CMD_ADDR_A, 8'h33);
        push_read(CMD_ADDR_A);
        push_write(CMD_ADDR_A, CMD_UNLOCK_1);
        push_write(CMD_ADDR_B, CMD_UNLOCK_2);
        push_write(CMD_ADDR_A, CMD_PROT_ON);
        push_write(15'h0000, 8'h77);
        push_read(15'h0000);
        push_write(CMD_ADDR_A, CMD_UNLOCK_1);
        push_write(CMD_ADDR_A, CMD_UNLOCK_1);
        push_write(CMD_ADDR_B, CMD_UNLOCK_2);
        for (int k = 0; k < 6; k++) push_write(off_addr[k], off_data[k]);
        push_read(CMD_ADDR_B);

        while (pending_accesses.size() < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                push_step(CMD_ADDR_A, CMD_UNLOCK_1);
                push_step(CMD_ADDR_B, CMD_UNLOCK_2);
                push_step(CMD_ADDR_A, CMD_PROT_ON);
            end else if (pick < 42) begin
                for (int k = 0; k < 6; k++) push_step(off_addr[k], off_data[k]);
            end else if (pick < 60) begin
                cut = $urandom_range(1, 5);
                for (int k = 0; k < cut; k++) push_step(off_addr[k], off_data[k]);
                push_step(pick_address(), pick_data());
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if (logic'($urandom_range(1))) push_read(pick_address());
                    else push_write(pick_address(), pick_data());
                end
            end
        end
        total_items = pending_accesses.size();

        @(posedge i_clk);
        while (accepted < total_items || awaited_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failed) begin
            $display("tb_protected_save_ram_unit: FAIL");
        end else begin
            $display("tb_protected_save_ram_unit: PASS");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        t_outcome r;
        bit       calm;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_access(on_bus, r);
                awaited_results.push_back(r);
                accepted++;
            end
            if (!i_valid || !o_stall) begin
                calm = (accepted >= 600 && accepted < 850);
                if (pending_accesses.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
                    on_bus = pending_accesses.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= on_bus.kind;
                    i_address <= on_bus.addr;
                    i_write_data <= on_bus.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected item: read_data %h, protect_on %b",
                           o_read_data, o_protect_on);
                    failed = 1'b1;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, o_read_data);
                        failed = 1'b1;
                    end
                    if (o_protect_on !== want.protect_on) begin
                        $error("protect_on: expected %b, got %b",
                               want.protect_on, o_protect_on);
                        failed = 1'b1;
                    end
                end
                received++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (received >= 300 && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else if (received >= 1000 && received < 1200) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 12);
            end
        end
    end

endmodule

FILE: files.f
rtl/psr_pkg.sv
rtl/psr_ram.sv
rtl/psr_seq.sv
rtl/protected_save_ram_unit.sv
tb/tb_protected_save_ram_unit.sv
